### design/wav_header_parser_assert.svh
// Assertion macros for the wav_header_parser checker.
// Depends on nothing; included by the checker file only.
`ifndef WAV_HEADER_PARSER_ASSERT_SVH
`define WAV_HEADER_PARSER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define WAVHP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("wav_header_parser: assertion failed");

// Check that a signal is stable in the cycle after a condition.
`define WAVHP_ASSERT_HOLD(lbl, clk, rstn, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> $stable(sig)) \
    else $error("wav_header_parser: signal did not hold");

`endif

### design/wavhp_pkg.sv
// Shared types and constants of the WAV header parser.
// No dependencies; imported by all parser modules and the checker.
`timescale 1ns / 1ps

package wavhp_pkg;

  localparam int unsigned RateW = 19;
  localparam logic [RateW-1:0] RATE_RESET = 19'd22050;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [7:0]  BITS_PER_SAMPLE = 8'd16;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FMT_BAD   = 3'd1,
    ST_BAD_RIFF  = 3'd2,
    ST_SHORT_FMT = 3'd3,
    ST_TRUNC     = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_CHUNK  = 5'b00010,
    PH_FMT    = 5'b00100,
    PH_SKIP   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] data_size;
  } result_t;

endpackage

### design/wavhp_in_stage.sv
// Input register of the WAV header parser.
// Depends on wavhp_pkg for the input beat type.
`timescale 1ns / 1ps

module wavhp_in_stage
  import wavhp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_beat_t beat_i,
  input  logic     fire_i,
  output logic     valid_o,
  output in_beat_t beat_o
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;
  logic     load;

  assign in_stall_o = valid_q && !fire_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (fire_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

### design/wavhp_parse.sv
// Parser state and per-byte next-state logic of the WAV header parser.
// Depends on wavhp_pkg for tags, phases, status codes and beat types.
`timescale 1ns / 1ps

module wavhp_parse
  import wavhp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [RateW-1:0] cfg_rate_i,
  input  logic             fire_i,
  input  in_beat_t         beat_i,
  output logic             emit_o,
  output result_t          result_o
);

  phase_e           phase_q, phase_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [31:0]      tag_q, tag_d;
  logic [31:0]      len_q, len_d;
  logic [32:0]      skip_q, skip_d;
  logic             fmt_ok_q, fmt_ok_d;
  logic             match_q, match_d;
  logic [RateW-1:0] rate_q;

  logic [31:0] tag_shift;
  logic [31:0] len_shift;
  logic [32:0] skip_n;
  logic [32:0] skip_nxt;
  logic [8:0]  expect_b;
  logic        emit;
  result_t     res;

  // Bit 8 set: byte is checked against bits 7:0.
  function automatic logic [8:0] fmt_expect(input logic [3:0] k,
                                            input logic [RateW-1:0] rate);
    logic [8:0] e;
    case (k)
      4'd0:    e = {1'b1, 8'h01};
      4'd1:    e = {1'b1, 8'h00};
      4'd2:    e = {1'b1, 8'h01};
      4'd3:    e = {1'b1, 8'h00};
      4'd4:    e = {1'b1, rate[7:0]};
      4'd5:    e = {1'b1, rate[15:8]};
      4'd6:    e = {1'b1, 5'd0, rate[18:16]};
      4'd7:    e = {1'b1, 8'h00};
      4'd14:   e = {1'b1, BITS_PER_SAMPLE};
      4'd15:   e = {1'b1, 8'h00};
      default: e = {1'b0, 8'h00};
    endcase
    return e;
  endfunction

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    tag_d    = tag_q;
    len_d    = len_q;
    skip_d   = skip_q;
    fmt_ok_d = fmt_ok_q;
    match_d  = match_q;
    emit     = 1'b0;
    res.status    = ST_OK;
    res.data_size = 32'd0;

    tag_shift = {tag_q[23:0], beat_i.data_byte};
    len_shift = {beat_i.data_byte, len_q[31:8]};
    expect_b  = fmt_expect(cnt_q, rate_q);
    skip_n    = 33'd0;
    skip_nxt  = (skip_q != 33'd0) ? (skip_q - 33'd1) : skip_q;

    if (fire_i) begin
      case (phase_q)
        PH_HEADER: begin
          tag_d = tag_shift;
          if (cnt_q == 4'd3 && tag_shift != TAG_RIFF) begin
            match_d = 1'b0;
          end
          if (cnt_q == 4'd11) begin
            if (!match_q || tag_shift != TAG_WAVE) begin
              match_d    = 1'b0;
              emit       = 1'b1;
              res.status = ST_BAD_RIFF;
              phase_d    = PH_DONE;
            end else begin
              phase_d = PH_CHUNK;
              cnt_d   = 4'd0;
            end
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        PH_CHUNK: begin
          if (cnt_q < 4'd4) begin
            tag_d = tag_shift;
          end else begin
            len_d = len_shift;
          end
          if (cnt_q == 4'd7) begin
            cnt_d = 4'd0;
            if (tag_q == TAG_DATA) begin
              emit          = 1'b1;
              res.status    = fmt_ok_q ? ST_OK : ST_FMT_BAD;
              res.data_size = len_shift;
              phase_d       = PH_DONE;
            end else if (tag_q == TAG_FMT) begin
              if (len_shift < FMT_MIN_LEN) begin
                emit       = 1'b1;
                res.status = ST_SHORT_FMT;
                phase_d    = PH_DONE;
              end else begin
                match_d = 1'b1;
                phase_d = PH_FMT;
              end
            end else begin
              skip_n  = {1'b0, len_shift} + {32'd0, len_shift[0]};
              skip_d  = skip_n;
              phase_d = (skip_n != 33'd0) ? PH_SKIP : PH_CHUNK;
            end
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        PH_FMT: begin
          if (expect_b[8] && beat_i.data_byte != expect_b[7:0]) begin
            match_d = 1'b0;
          end
          if (cnt_q == 4'd15) begin
            fmt_ok_d = match_d;
            skip_n   = {1'b0, len_q - FMT_MIN_LEN} + {32'd0, len_q[0]};
            skip_d   = skip_n;
            cnt_d    = 4'd0;
            phase_d  = (skip_n != 33'd0) ? PH_SKIP : PH_CHUNK;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        PH_SKIP: begin
          skip_d = skip_nxt;
          if (skip_nxt == 33'd0) begin
            phase_d = PH_CHUNK;
            cnt_d   = 4'd0;
          end
        end
        default: begin
        end
      endcase

      if (beat_i.last_byte) begin
        if (!emit && phase_q != PH_DONE) begin
          emit          = 1'b1;
          res.status    = ST_TRUNC;
          res.data_size = 32'd0;
        end
        phase_d  = PH_HEADER;
        cnt_d    = 4'd0;
        tag_d    = 32'd0;
        len_d    = 32'd0;
        skip_d   = 33'd0;
        fmt_ok_d = 1'b0;
        match_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      cnt_q    <= 4'd0;
      tag_q    <= 32'd0;
      len_q    <= 32'd0;
      skip_q   <= 33'd0;
      fmt_ok_q <= 1'b0;
      match_q  <= 1'b1;
      rate_q   <= RATE_RESET;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      tag_q    <= tag_d;
      len_q    <= len_d;
      skip_q   <= skip_d;
      fmt_ok_q <= fmt_ok_d;
      match_q  <= match_d;
      if (cfg_we_i) begin
        rate_q <= cfg_rate_i;
      end
    end
  end

  assign emit_o   = emit;
  assign result_o = res;

endmodule

### design/wavhp_out_stage.sv
// Result register of the WAV header parser.
// Depends on wavhp_pkg for the result type.
`timescale 1ns / 1ps

module wavhp_out_stage
  import wavhp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t result_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = push_i ? 1'b1 : (out_stall_i ? valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

### design/wav_header_parser.sv
// Top level of the WAV header parser: input register, parser, result register.
// Depends on wavhp_pkg, wavhp_in_stage, wavhp_parse and wavhp_out_stage.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  data_byte_i, last_byte_i
//   out      output     out_valid_o/out_stall_i status_o, data_size_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (expected rate)
//
// One byte per cycle unless the result register stalls; results are registered.
// The parser advances on a byte only when the result register can take a beat.
// Reset clears parser state and sets the expected rate to 22050.
// A stalled result holds; an empty input register still takes one more byte.
`timescale 1ns / 1ps

module wav_header_parser
  import wavhp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       status_o,
  output logic [31:0]      data_size_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [RateW-1:0] cfg_data_i
);

  in_beat_t in_beat;
  in_beat_t s1_beat;
  logic     s1_valid;
  logic     out_ready;
  logic     fire;
  logic     emit;
  result_t  res;
  result_t  out_res;

  assign in_beat.data_byte = data_byte_i;
  assign in_beat.last_byte = last_byte_i;
  assign fire              = s1_valid && out_ready;
  assign cfg_ready_o       = 1'b1;

  wavhp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .beat_i     (in_beat),
    .fire_i     (fire),
    .valid_o    (s1_valid),
    .beat_o     (s1_beat)
  );

  wavhp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_rate_i (cfg_data_i),
    .fire_i     (fire),
    .beat_i     (s1_beat),
    .emit_o     (emit),
    .result_o   (res)
  );

  wavhp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .result_i    (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign status_o    = out_res.status;
  assign data_size_o = out_res.data_size;

endmodule

### design/wavhp_checker.sv
// Port-level checker for the WAV header parser, bound to the top level.
// Depends on wavhp_pkg and wav_header_parser_assert.svh.
`timescale 1ns / 1ps
`include "wav_header_parser_assert.svh"

module wavhp_checker
  import wavhp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [7:0]       data_byte_i,
  input logic             last_byte_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [2:0]       status_o,
  input logic [31:0]      data_size_o,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o,
  input logic [RateW-1:0] cfg_data_i
);

  `WAVHP_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, {out_valid_o, status_o, data_size_o})
  `WAVHP_ASSERT(a_status_range, clk_i, rst_ni, out_valid_o |-> (status_o <= ST_TRUNC))
  `WAVHP_ASSERT(a_size_zero, clk_i, rst_ni, (out_valid_o && status_o != ST_OK && status_o != ST_FMT_BAD) |-> (data_size_o == 32'd0))
  `WAVHP_ASSERT(a_out_latency, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))

endmodule

bind wav_header_parser wavhp_checker u_wavhp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .data_byte_i (data_byte_i),
  .last_byte_i (last_byte_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .data_size_o (data_size_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i)
);

### tb/testbench.sv
// Self-checking testbench for wav_header_parser: streams WAV files one byte per beat,
// predicts each verdict in a behavioral parser model and compares every result beat.
// Depends on wavhp_pkg and the wav_header_parser RTL.
`timescale 1ns / 1ps

module testbench;
  import wavhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PRINT_CAP = 40;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       data_byte_i = 8'd0;
  logic             last_byte_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [2:0]       status_o;
  logic [31:0]      data_size_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [RateW-1:0] cfg_data_i = '0;

  wav_header_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_size_o (data_size_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  in_beat_t         bytes_to_send[$];
  in_beat_t         file_q[$];
  result_t          verdicts_due[$];
  in_beat_t         next_beat;
  result_t          verdict_head;

  logic             calm = 1'b0;
  logic             hold_req = 1'b0;
  logic             hold_done;
  int unsigned      hold_left;
  int unsigned      cycle_count = 0;
  int unsigned      mismatches = 0;
  int unsigned      verdicts_seen = 0;
  int unsigned      bytes_taken = 0;
  int unsigned      bytes_queued = 0;
  int unsigned      files_sent = 0;
  int unsigned      rate_writes = 0;
  logic [RateW-1:0] cur_rate;
  logic [RateW-1:0] rate_plan [0:5];

  // parser model state
  phase_e           wav_phase;
  logic [4:0]       wav_count;
  logic [31:0]      wav_tag;
  logic [31:0]      wav_len;
  logic [32:0]      wav_skip;
  logic             fmt_ok;
  logic             fmt_fields_ok;
  logic             verdict_given;
  logic [RateW-1:0] model_rate;

  task automatic clear_parser();
    wav_phase = PH_HEADER;
    wav_count = '0;
    wav_tag = '0;
    wav_len = '0;
    wav_skip = '0;
    fmt_ok = 1'b0;
    fmt_fields_ok = 1'b1;
    verdict_given = 1'b0;
  endtask

  task automatic begin_skip(input logic [32:0] n);
    wav_skip = n;
    wav_count = '0;
    if (n != 0) begin
      wav_phase = PH_SKIP;
    end else begin
      wav_phase = PH_CHUNK;
    end
  endtask

  task automatic parse_wav_byte(input logic [7:0] b, input logic fin);
    logic        hit;
    result_t     r;
    logic [31:0] rate_w;
    logic [8:0]  want;
    hit = 1'b0;
    r.status = ST_OK;
    r.data_size = '0;
    rate_w = {{(32 - RateW){1'b0}}, model_rate};
    case (wav_phase)
      PH_HEADER: begin
        wav_tag = {wav_tag[23:0], b};
        if (wav_count == 5'd3 && wav_tag != TAG_RIFF) fmt_fields_ok = 1'b0;
        if (wav_count == 5'd11) begin
          if (wav_tag != TAG_WAVE) fmt_fields_ok = 1'b0;
          if (!fmt_fields_ok) begin
            hit = 1'b1;
            r.status = ST_BAD_RIFF;
            verdict_given = 1'b1;
            wav_phase = PH_DONE;
          end else begin
            wav_phase = PH_CHUNK;
            wav_count = '0;
          end
        end else begin
          wav_count = wav_count + 5'd1;
        end
      end
      PH_CHUNK: begin
        if (wav_count < 5'd4) wav_tag = {wav_tag[23:0], b};
        else wav_len = {b, wav_len[31:8]};
        if (wav_count == 5'd7) begin
          wav_count = '0;
          if (wav_tag == TAG_DATA) begin
            hit = 1'b1;
            r.status = fmt_ok ? ST_OK : ST_FMT_BAD;
            r.data_size = wav_len;
            verdict_given = 1'b1;
            wav_phase = PH_DONE;
          end else if (wav_tag == TAG_FMT) begin
            if (wav_len < FMT_MIN_LEN) begin
              hit = 1'b1;
              r.status = ST_SHORT_FMT;
              verdict_given = 1'b1;
              wav_phase = PH_DONE;
            end else begin
              fmt_fields_ok = 1'b1;
              wav_phase = PH_FMT;
            end
          end else begin
            begin_skip({1'b0, wav_len} + wav_len[0]);
          end
        end else begin
          wav_count = wav_count + 5'd1;
        end
      end
      PH_FMT: begin
        case (wav_count)
          5'd0, 5'd2: want = 9'd1;
          5'd1, 5'd3, 5'd15: want = 9'd0;
          5'd4, 5'd5, 5'd6, 5'd7: want = {1'b0, rate_w[8 * (wav_count - 5'd4) +: 8]};
          5'd14: want = {1'b0, BITS_PER_SAMPLE};
          default: want = 9'h100;
        endcase
        if (!want[8] && b != want[7:0]) fmt_fields_ok = 1'b0;
        if (wav_count >= 5'd15) begin
          fmt_ok = fmt_fields_ok;
          begin_skip({1'b0, wav_len - FMT_MIN_LEN} + wav_len[0]);
        end else begin
          wav_count = wav_count + 5'd1;
        end
      end
      PH_SKIP: begin
        if (wav_skip != 0) wav_skip = wav_skip - 33'd1;
        if (wav_skip == 0) begin
          wav_phase = PH_CHUNK;
          wav_count = '0;
        end
      end
      default: ;
    endcase
    if (fin) begin
      if (!hit && !verdict_given) begin
        hit = 1'b1;
        r.status = ST_TRUNC;
        r.data_size = '0;
      end
      clear_parser();
    end
    if (hit) verdicts_due.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
  endtask

  // driver: present pending bytes, predict on every accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_wav_byte(data_byte_i, last_byte_i);
        bytes_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (bytes_to_send.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
          next_beat = bytes_to_send.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= next_beat.data_byte;
          last_byte_i <= next_beat.last_byte;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: check result beats, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected result, status", {29'd0, status_o}, 32'd0);
        end else begin
          verdict_head = verdicts_due.pop_front();
          verdicts_seen++;
          if (status_o !== verdict_head.status)
            report_mismatch("status", {29'd0, status_o}, {29'd0, verdict_head.status});
          if (data_size_o !== verdict_head.data_size)
            report_mismatch("data_size", data_size_o, verdict_head.data_size);
        end
      end
      out_stall_i <= (hold_left != 0) || (!calm && $urandom_range(99) < 27);
    end
  end

  // long output hold, once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("wav_header_parser: mismatch");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b);
    file_q.push_back({b, 1'b0});
  endtask

  task automatic add_noise(input int unsigned n);
    repeat (n) add_byte($urandom);
  endtask

  task automatic add_le32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8 * i +: 8]);
  endtask

  task automatic add_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) add_byte(t[8 * i +: 8]);
  endtask

  task automatic add_riff(input logic [31:0] riff, input logic [31:0] wave);
    add_tag(riff);
    add_le32($urandom);
    add_tag(wave);
  endtask

  task automatic add_chunk(input logic [31:0] t, input logic [31:0] len);
    add_tag(t);
    add_le32(len);
    if (len < 64) add_noise(len + len[0]);
  endtask

  task automatic add_fmt(input logic [31:0] len, input logic [15:0] ftag,
                         input logic [15:0] chans, input logic [31:0] rate,
                         input logic [15:0] bits);
    add_tag(TAG_FMT);
    add_le32(len);
    add_byte(ftag[7:0]);
    add_byte(ftag[15:8]);
    add_byte(chans[7:0]);
    add_byte(chans[15:8]);
    add_le32(rate);
    add_noise(6);
    add_byte(bits[7:0]);
    add_byte(bits[15:8]);
    if (len < 64) add_noise(len - 16 + len[0]);
  endtask

  task automatic add_good_fmt(input logic [31:0] len);
    add_fmt(len, 16'd1, 16'd1, {{(32 - RateW){1'b0}}, cur_rate}, 16'd16);
  endtask

  // flip one bit of one checked field
  task automatic add_bad_fmt(input logic [31:0] len, input int fault, input int pos);
    logic [15:0] ftag;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    ftag = 16'd1;
    chans = 16'd1;
    rate = {{(32 - RateW){1'b0}}, cur_rate};
    bits = 16'd16;
    case (fault)
      0: ftag ^= 16'd1 << (pos % 16);
      1: chans ^= 16'd1 << (pos % 16);
      2: rate ^= 32'd1 << pos;
      default: bits ^= 16'd1 << (pos % 16);
    endcase
    add_fmt(len, ftag, chans, rate, bits);
  endtask

  task automatic add_data(input logic [31:0] size);
    add_tag(TAG_DATA);
    add_le32(size);
  endtask

  // mark the final byte, optionally cut the file short first, and queue it
  task automatic send_file(input bit cut);
    in_beat_t    tail;
    int unsigned keep;
    if (cut) begin
      keep = $urandom_range(0, file_q.size() - 1);
      while (file_q.size() > keep + 1) file_q.delete(file_q.size() - 1);
    end
    tail = file_q.pop_back();
    tail.last_byte = 1'b1;
    file_q.push_back(tail);
    foreach (file_q[i]) bytes_to_send.push_back(file_q[i]);
    bytes_queued += file_q.size();
    files_sent++;
    file_q.delete();
  endtask

  function automatic logic [31:0] other_tag();
    logic [31:0] t;
    t = $urandom;
    if (t == TAG_DATA || t == TAG_FMT) t ^= 32'd1;
    return t;
  endfunction

  task automatic random_wav_file();
    int unsigned kind;
    int unsigned flip;
    logic [31:0] riff;
    logic [31:0] wave;
    kind = $urandom_range(99);
    if (kind < 70) begin
      add_riff(TAG_RIFF, TAG_WAVE);
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 2))
          0: add_chunk(other_tag(), $urandom_range(0, 9));
          1: add_good_fmt($urandom_range(16, 21));
          default: add_bad_fmt($urandom_range(16, 21), $urandom_range(0, 3),
                               $urandom_range(0, 31));
        endcase
      end
      add_data($urandom);
      add_noise($urandom_range(0, 3));
      send_file($urandom_range(0, 9) == 0);
    end else if (kind < 80) begin
      riff = TAG_RIFF;
      wave = TAG_WAVE;
      flip = $urandom_range(0, 63);
      if (flip < 32) riff ^= 32'd1 << flip;
      else wave ^= 32'd1 << (flip - 32);
      add_riff(riff, wave);
      add_noise($urandom_range(0, 4));
      send_file(1'b0);
    end else if (kind < 88) begin
      add_riff(TAG_RIFF, TAG_WAVE);
      if ($urandom_range(0, 1)) add_chunk(other_tag(), $urandom_range(0, 5));
      add_tag(TAG_FMT);
      add_le32($urandom_range(0, 15));
      add_noise($urandom_range(0, 3));
      send_file(1'b0);
    end else begin
      add_noise($urandom_range(1, 24));
      send_file(1'b0);
    end
  endtask

  task automatic random_files();
    int unsigned files0;
    int unsigned bytes0;
    files0 = files_sent;
    bytes0 = bytes_queued;
    while (files_sent - files0 < 7 || bytes_queued - bytes0 < 92) random_wav_file();
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (bytes_to_send.size() != 0 || in_valid_i || verdicts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [RateW-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model_rate = v;
    cur_rate = v;
    rate_writes++;
  endtask

  initial begin
    clear_parser();
    model_rate = RATE_RESET;
    cur_rate = RATE_RESET;
    rate_plan[0] = 19'd1;
    rate_plan[1] = 19'd384000;
    rate_plan[2] = 19'd0;
    rate_plan[3] = 19'h7FFFF;
    rate_plan[4] = 19'd44100;
    rate_plan[5] = $urandom_range(1, 384000);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // good file, trailing bytes ignored
    add_riff(TAG_RIFF, TAG_WAVE);
    add_good_fmt(16);
    add_data(32'h1234_5678);
    add_noise(3);
    send_file(1'b0);
    // odd unknown chunk, odd fmt, final byte completes the data header
    add_riff(TAG_RIFF, TAG_WAVE);
    add_chunk(32'h4C49_5354, 3);
    add_good_fmt(17);
    add_data(32'd0);
    send_file(1'b0);
    // data without fmt
    add_riff(TAG_RIFF, TAG_WAVE);
    add_data(32'hFFFF_FFFF);
    add_noise(1);
    send_file(1'b0);
    // bad RIFF, bad WAVE ending on the twelfth byte
    add_riff(TAG_RIFF ^ 32'd1, TAG_WAVE);
    add_noise(2);
    send_file(1'b0);
    add_riff(TAG_RIFF, TAG_WAVE ^ 32'h8000_0000);
    send_file(1'b0);
    // short fmt chunks
    add_riff(TAG_RIFF, TAG_WAVE);
    add_tag(TAG_FMT);
    add_le32(32'd15);
    add_noise(2);
    send_file(1'b0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_tag(TAG_FMT);
    add_le32(32'd0);
    send_file(1'b0);
    // one bad field at a time
    for (int f = 0; f < 4; f++) begin
      add_riff(TAG_RIFF, TAG_WAVE);
      add_bad_fmt(16, f, 1);
      add_data(32'd8);
      send_file(1'b0);
    end
    // last fmt wins, both orders
    add_riff(TAG_RIFF, TAG_WAVE);
    add_good_fmt(16);
    add_bad_fmt(18, 3, 3);
    add_data(32'd100);
    send_file(1'b0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_bad_fmt(16, 2, 0);
    add_good_fmt(16);
    add_data(32'd100);
    send_file(1'b0);
    // empty chunk
    add_riff(TAG_RIFF, TAG_WAVE);
    add_chunk(32'h4A55_4E4B, 0);
    add_good_fmt(16);
    add_data(32'd2);
    send_file(1'b0);
    // truncations: lone byte, header, chunk header, fmt body, huge skip, huge fmt
    add_byte(8'hFF);
    send_file(1'b0);
    add_riff(TAG_RIFF, TAG_WAVE);
    while (file_q.size() > 5) file_q.delete(file_q.size() - 1);
    send_file(1'b0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_tag(TAG_DATA);
    add_byte(8'h00);
    send_file(1'b0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_good_fmt(16);
    while (file_q.size() > 30) file_q.delete(file_q.size() - 1);
    send_file(1'b0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_chunk(32'h4A55_4E4B, 32'hFFFF_FFFF);
    add_noise(4);
    send_file(1'b0);
    add_riff(TAG_RIFF, TAG_WAVE);
    add_good_fmt(32'hFFFF_FFFF);
    add_noise(5);
    send_file(1'b0);

    random_files();

    for (int i = 0; i < 6; i++) begin
      wait_quiet();
      calm <= (i == 1);
      write_rate(rate_plan[i]);
      if (i == 4) hold_req <= 1'b1;
      random_files();
    end

    wait_quiet();
    $display("%0d verdicts checked over %0d bytes in %0d files", verdicts_seen, bytes_taken,
             files_sent);
    $display("%0d rate writes incl. 0, 1, 384000 and all ones; one long output hold",
             rate_writes);
    if (mismatches == 0) begin
      $display("wav_header_parser: match");
    end else begin
      $display("wav_header_parser: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/wavhp_pkg.sv
design/wavhp_in_stage.sv
design/wavhp_parse.sv
design/wavhp_out_stage.sv
design/wav_header_parser.sv
design/wavhp_checker.sv
tb/testbench.sv
